@@ rtl/tfli_pkg.sv @@
`timescale 1ns / 1ps

package tfli_pkg;

    localparam int SIZE_W = 32;
    localparam int ADDR_W = 32;
    localparam int IDX_W  = 5;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam int SL_COUNT_LOG2_DEF = 5;
    localparam int FL_COUNT_DEF      = 24;
    localparam int FL_SHIFT_DEF      = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SIZE_W-1:0] block_size;
        logic [ADDR_W-1:0] block_addr;
        logic [ADDR_W-1:0] next_addr;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  second_index;
        logic [ADDR_W-1:0] head_address;
    } t_out_item;

    // bitmap update from the result stage
    typedef struct packed {
        logic             pend_set;
        logic             clr;
        logic             commit;
        logic [IDX_W-1:0] fl;
        logic [IDX_W-1:0] sl;
    } t_bm_upd;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] fl;
        logic [IDX_W-1:0] sl;
    } t_srch;

    function automatic logic [IDX_W-1:0] oh_idx(input logic [SIZE_W-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                r = r | IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/tfli_class_map.sv @@
`timescale 1ns / 1ps

module tfli_class_map #(
    parameter int SL_COUNT_LOG2 = tfli_pkg::SL_COUNT_LOG2_DEF,
    parameter int FL_COUNT      = tfli_pkg::FL_COUNT_DEF,
    parameter int FL_SHIFT      = tfli_pkg::FL_SHIFT_DEF
) (
    input  logic [tfli_pkg::OP_W-1:0]   i_op,
    input  logic [tfli_pkg::SIZE_W-1:0] i_size,
    output logic                        o_ok,
    output logic [$clog2(FL_COUNT)-1:0] o_fl,
    output logic [SL_COUNT_LOG2-1:0]    o_sl
);
    import tfli_pkg::*;

    localparam int SLL  = SL_COUNT_LOG2;
    localparam int FLW  = $clog2(FL_COUNT);
    localparam int SH_R = (FL_SHIFT >= SLL) ? (FL_SHIFT - SLL) : 0;
    localparam int SH_L = (FL_SHIFT < SLL) ? (SLL - FL_SHIFT) : 0;
    localparam logic [SIZE_W-1:0] SMALL_LIM = SIZE_W'(1) << FL_SHIFT;

    logic                  is_tiny;
    logic [SIZE_W-1:0]     sm_sh;
    logic [SIZE_W-1:0]     oh;
    logic [SIZE_W+SLL-1:0] ext;
    logic [SLL-1:0]        sl_sel;
    logic                  rnd;
    logic [IDX_W-1:0]      msb;
    logic [IDX_W-1:0]      fl_big;
    logic [IDX_W-1:0]      fl_fin;
    logic [SLL:0]          sl_sum;
    logic [SLL-1:0]        sl_fin;
    logic                  op_ok;
    logic                  in_range;

    always_comb begin
        is_tiny = i_size < SMALL_LIM;
        sm_sh   = (FL_SHIFT >= SLL) ? (i_size >> SH_R) : (i_size << SH_L);
        ext     = {i_size, {SLL{1'b0}}};
        sl_sel  = '0;
        rnd     = 1'b0;
        // one-hot leading bit; the class slice is the SLL bits below it
        for (int i = 0; i < SIZE_W; i++) begin
            oh[i] = i_size[i] & ~|(i_size >> (i + 1));
            if (oh[i]) begin
                sl_sel = sl_sel | ext[i +: SLL];
            end
            if (i > SLL) begin
                if (oh[i] && ((i_size & ((SIZE_W'(1) << (i - SLL)) - SIZE_W'(1))) != '0)) begin
                    rnd = 1'b1;
                end
            end
        end
        msb    = oh_idx(oh);
        fl_big = msb - IDX_W'(FL_SHIFT - 1);
        // search rounds up to the next class boundary
        sl_sum = {1'b0, sl_sel} + {{SLL{1'b0}}, rnd & (i_op == OP_SEARCH)};
        if (is_tiny) begin
            fl_fin = '0;
            sl_fin = sm_sh[SLL-1:0];
        end else begin
            fl_fin = fl_big + IDX_W'(sl_sum[SLL]);
            sl_fin = sl_sum[SLL-1:0];
        end
        op_ok    = (i_op == OP_INSERT) || (i_op == OP_REMOVE) || (i_op == OP_SEARCH);
        in_range = {1'b0, fl_fin} < (IDX_W + 1)'(FL_COUNT);
        o_ok     = op_ok && (i_size != '0) && in_range;
        o_fl     = o_ok ? fl_fin[FLW-1:0] : '0;
        o_sl     = o_ok ? sl_fin : '0;
    end

endmodule

@@ rtl/tfli_bitmap.sv @@
`timescale 1ns / 1ps

module tfli_bitmap #(
    parameter int SL_COUNT_LOG2 = tfli_pkg::SL_COUNT_LOG2_DEF,
    parameter int FL_COUNT      = tfli_pkg::FL_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tfli_pkg::t_bm_upd           i_upd,
    input  logic [$clog2(FL_COUNT)-1:0] i_fl,
    input  logic [SL_COUNT_LOG2-1:0]    i_sl,
    output tfli_pkg::t_srch             o_res
);
    import tfli_pkg::*;

    localparam int SLL    = SL_COUNT_LOG2;
    localparam int SL_CNT = 1 << SLL;
    localparam int FLW    = $clog2(FL_COUNT);
    localparam logic [SL_CNT-1:0]   SL_ONE = {{(SL_CNT - 1){1'b0}}, 1'b1};
    localparam logic [FL_COUNT-1:0] FL_ONE = {{(FL_COUNT - 1){1'b0}}, 1'b1};

    logic [SL_CNT-1:0]   r_l2 [FL_COUNT];
    logic [SL_CNT-1:0]   n_l2 [FL_COUNT];
    logic [FL_COUNT-1:0] r_l1;
    logic [FL_COUNT-1:0] n_l1;

    logic [SL_CNT-1:0]   row_v  [FL_COUNT];
    logic [SL_CNT-1:0]   masked [FL_COUNT];
    logic [FL_COUNT-1:0] l1v;
    logic [FL_COUNT-1:0] cand;
    logic [FL_COUNT-1:0] iso;
    logic [SL_CNT-1:0]   slmask;
    logic [SL_CNT-1:0]   sel_row;
    logic [SL_CNT-1:0]   siso;
    logic [SL_CNT-1:0]   upd_bit;

    always_comb begin
        upd_bit = SL_ONE << i_upd.sl;
        slmask  = {SL_CNT{1'b1}} << i_sl;
        sel_row = '0;
        for (int r = 0; r < FL_COUNT; r++) begin
            n_l2[r] = r_l2[r];
            if (i_upd.commit && (i_upd.fl == IDX_W'(r))) begin
                if (i_upd.pend_set) begin
                    n_l2[r] = n_l2[r] | upd_bit;
                end
                if (i_upd.clr) begin
                    n_l2[r] = n_l2[r] & ~upd_bit;
                end
            end
            n_l1[r] = |n_l2[r];

            // pending insert in the result stage is forwarded
            row_v[r] = r_l2[r];
            l1v[r]   = r_l1[r];
            if (i_upd.pend_set && (i_upd.fl == IDX_W'(r))) begin
                row_v[r] = row_v[r] | upd_bit;
                l1v[r]   = 1'b1;
            end
            if (FLW'(r) == i_fl) begin
                masked[r] = row_v[r] & slmask;
                cand[r]   = |masked[r];
            end else begin
                masked[r] = row_v[r];
                cand[r]   = (FLW'(r) > i_fl) && l1v[r];
            end
        end
        iso = cand & (~cand + FL_ONE);
        for (int r = 0; r < FL_COUNT; r++) begin
            if (iso[r]) begin
                sel_row = sel_row | masked[r];
            end
        end
        siso        = sel_row & (~sel_row + SL_ONE);
        o_res.found = |cand;
        o_res.fl    = oh_idx(SIZE_W'(iso));
        o_res.sl    = oh_idx(SIZE_W'(siso));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= '0;
            for (int r = 0; r < FL_COUNT; r++) begin
                r_l2[r] <= '0;
            end
        end else if (i_upd.commit) begin
            r_l1 <= n_l1;
            for (int r = 0; r < FL_COUNT; r++) begin
                r_l2[r] <= n_l2[r];
            end
        end
    end

endmodule

@@ rtl/tfli_head_mem.sv @@
`timescale 1ns / 1ps

module tfli_head_mem #(
    parameter int SL_COUNT_LOG2 = tfli_pkg::SL_COUNT_LOG2_DEF,
    parameter int FL_COUNT      = tfli_pkg::FL_COUNT_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_rd_en,
    input  logic [$clog2(FL_COUNT)+SL_COUNT_LOG2-1:0] i_rd_addr,
    output logic [tfli_pkg::ADDR_W-1:0]               o_rd_data,
    input  logic                                      i_wr_en,
    input  logic [$clog2(FL_COUNT)+SL_COUNT_LOG2-1:0] i_wr_addr,
    input  logic [tfli_pkg::ADDR_W-1:0]               i_wr_data,
    output logic                                      o_busy
);
    import tfli_pkg::*;

    localparam int DEPTH = FL_COUNT << SL_COUNT_LOG2;
    localparam int HAW   = $clog2(FL_COUNT) + SL_COUNT_LOG2;

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] r_rd;
    logic [ADDR_W-1:0] r_fwd_data;
    logic              r_fwd;
    logic              r_clr_busy;
    logic [HAW-1:0]    r_clr_addr;
    logic              we;
    logic [HAW-1:0]    wa;
    logic [ADDR_W-1:0] wd;

    assign we        = r_clr_busy || i_wr_en;
    assign wa        = r_clr_busy ? r_clr_addr : i_wr_addr;
    assign wd        = r_clr_busy ? '0 : i_wr_data;
    assign o_rd_data = r_fwd ? r_fwd_data : r_rd;
    assign o_busy    = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (i_rd_en) begin
            r_rd       <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // read and write to the same entry in one cycle: take the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == HAW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + HAW'(1);
        end
    end

endmodule

@@ rtl/tlsf_free_list_index.sv @@
// Pipeline: stage 0, class lookup stage, result stage, output register.
// Throughput: one item per cycle while the output is not stalled; a search
// directly behind a remove with a null next waits for the bitmap update.
// Reset: synchronous, active low. Clears bitmaps and pipeline, then clears
// the head table, one entry per cycle, FL_COUNT << SL_COUNT_LOG2 entries
// (768 by default), with o_in_ready low.
`timescale 1ns / 1ps

module tlsf_free_list_index #(
    parameter int SL_COUNT_LOG2 = tfli_pkg::SL_COUNT_LOG2_DEF,
    parameter int FL_COUNT      = tfli_pkg::FL_COUNT_DEF,
    parameter int FL_SHIFT      = tfli_pkg::FL_SHIFT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tfli_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tfli_pkg::t_out_item o_out_data
);
    import tfli_pkg::*;

    localparam int SLL = SL_COUNT_LOG2;
    localparam int FLW = $clog2(FL_COUNT);

    logic              r_s0_valid;
    t_in_item          r_s0;

    logic              m_ok;
    logic [FLW-1:0]    m_fl;
    logic [SLL-1:0]    m_sl;

    logic              r_s1_valid;
    logic [OP_W-1:0]   r_s1_op;
    logic              r_s1_ok;
    logic [FLW-1:0]    r_s1_fl;
    logic [SLL-1:0]    r_s1_sl;
    logic [ADDR_W-1:0] r_s1_blk;
    logic [ADDR_W-1:0] r_s1_next;

    t_srch             srch;
    logic              s1_hit;
    logic [FLW-1:0]    s1_fl;
    logic [SLL-1:0]    s1_sl;

    logic              r_s2_valid;
    logic [OP_W-1:0]   r_s2_op;
    logic              r_s2_ok;
    logic              r_s2_found;
    logic [FLW-1:0]    r_s2_fl;
    logic [SLL-1:0]    r_s2_sl;
    logic [ADDR_W-1:0] r_s2_blk;
    logic [ADDR_W-1:0] r_s2_next;

    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    logic              out_free;
    logic              s2_adv;
    logic              s2_free;
    logic              s1_adv;
    logic              s1_free;
    logic              s0_adv;
    logic              s0_free;
    logic              in_xfer;
    logic              hazard;
    logic              clr_busy;

    t_bm_upd           upd;
    logic [ADDR_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_data;
    logic              s2_ins;
    logic              s2_rem;
    logic              s2_match;

    tfli_class_map #(
        .SL_COUNT_LOG2 (SL_COUNT_LOG2),
        .FL_COUNT      (FL_COUNT),
        .FL_SHIFT      (FL_SHIFT)
    ) u_class_map (
        .i_op   (r_s0.operation),
        .i_size (r_s0.block_size),
        .o_ok   (m_ok),
        .o_fl   (m_fl),
        .o_sl   (m_sl)
    );

    tfli_bitmap #(
        .SL_COUNT_LOG2 (SL_COUNT_LOG2),
        .FL_COUNT      (FL_COUNT)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .i_fl    (r_s1_fl),
        .i_sl    (r_s1_sl),
        .o_res   (srch)
    );

    tfli_head_mem #(
        .SL_COUNT_LOG2 (SL_COUNT_LOG2),
        .FL_COUNT      (FL_COUNT)
    ) u_head_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s1_adv),
        .i_rd_addr ({s1_fl, s1_sl}),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr ({r_s2_fl, r_s2_sl}),
        .i_wr_data (wr_data),
        .o_busy    (clr_busy)
    );

    // flow control
    assign hazard   = r_s2_valid && r_s2_ok && (r_s2_op == OP_REMOVE) &&
                      (r_s2_next == '0) && (r_s1_op == OP_SEARCH);
    assign out_free = !r_out_valid || i_out_ready;
    assign s2_adv   = r_s2_valid && out_free;
    assign s2_free  = !r_s2_valid || s2_adv;
    assign s1_adv   = r_s1_valid && s2_free && !hazard;
    assign s1_free  = !r_s1_valid || s1_adv;
    assign s0_adv   = r_s0_valid && s1_free;
    assign s0_free  = !r_s0_valid || s0_adv;
    assign o_in_ready = s0_free && !clr_busy;
    assign in_xfer  = i_in_valid && o_in_ready;

    // class lookup stage
    assign s1_hit = (r_s1_op == OP_SEARCH) && srch.found;
    assign s1_fl  = s1_hit ? srch.fl[FLW-1:0] : r_s1_fl;
    assign s1_sl  = s1_hit ? srch.sl[SLL-1:0] : r_s1_sl;

    // result stage
    assign s2_ins   = r_s2_valid && r_s2_ok && (r_s2_op == OP_INSERT);
    assign s2_rem   = r_s2_valid && r_s2_ok && (r_s2_op == OP_REMOVE);
    assign s2_match = rd_data == r_s2_blk;
    assign wr_en    = s2_adv && (s2_ins || (s2_rem && s2_match));
    assign wr_data  = s2_ins ? r_s2_blk : r_s2_next;

    always_comb begin
        upd.pend_set = s2_ins;
        upd.clr      = s2_rem && s2_match && (r_s2_next == '0);
        upd.commit   = s2_adv;
        upd.fl       = IDX_W'(r_s2_fl);
        upd.sl       = IDX_W'(r_s2_sl);
    end

    always_comb begin
        n_out.status       = ST_RANGE;
        n_out.first_index  = '0;
        n_out.second_index = '0;
        n_out.head_address = '0;
        if (r_s2_ok) begin
            n_out.status       = ST_OK;
            n_out.first_index  = IDX_W'(r_s2_fl);
            n_out.second_index = IDX_W'(r_s2_sl);
            case (r_s2_op)
                OP_INSERT: begin
                    n_out.head_address = rd_data;
                end
                OP_REMOVE: begin
                    n_out.head_address = s2_match ? r_s2_next : rd_data;
                end
                OP_SEARCH: begin
                    if (r_s2_found) begin
                        n_out.head_address = rd_data;
                    end else begin
                        n_out.status = ST_EMPTY;
                    end
                end
                default: begin
                    n_out.status = ST_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s0_valid <= 1'b1;
            end else if (s0_adv) begin
                r_s0_valid <= 1'b0;
            end
            if (s0_adv) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s0 <= i_in_data;
        end
        if (s0_adv) begin
            r_s1_op   <= r_s0.operation;
            r_s1_ok   <= m_ok;
            r_s1_fl   <= m_fl;
            r_s1_sl   <= m_sl;
            r_s1_blk  <= r_s0.block_addr;
            r_s1_next <= r_s0.next_addr;
        end
        if (s1_adv) begin
            r_s2_op    <= r_s1_op;
            r_s2_ok    <= r_s1_ok;
            r_s2_found <= srch.found;
            r_s2_fl    <= s1_fl;
            r_s2_sl    <= s1_sl;
            r_s2_blk   <= r_s1_blk;
            r_s2_next  <= r_s1_next;
        end
        if (s2_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/tfli_checker.sv @@
`timescale 1ns / 1ps

module tfli_checker #(
    parameter int FL_COUNT = tfli_pkg::FL_COUNT_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tfli_pkg::t_out_item o_out_data
);
    import tfli_pkg::*;

    // head table clear keeps input closed right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("transfer possible right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_RANGE) |->
            (o_out_data.first_index == '0) && (o_out_data.second_index == '0) &&
            (o_out_data.head_address == '0))
        else $error("range error with nonzero fields");

    a_class_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_RANGE) |->
            ({1'b0, o_out_data.first_index} < (IDX_W + 1)'(FL_COUNT)) &&
            ((o_out_data.status != ST_EMPTY) || (o_out_data.head_address == '0)))
        else $error("class out of range or empty search with head");

endmodule

bind tlsf_free_list_index tfli_checker #(.FL_COUNT(FL_COUNT)) u_tfli_checker (.*);

@@ bench/tb_tlsf_free_list_index.sv @@
`timescale 1ns / 1ps

module tb_tlsf_free_list_index;
    import tfli_pkg::*;

    localparam int SLL        = SL_COUNT_LOG2_DEF;
    localparam int SL_COUNT   = 1 << SLL;
    localparam int FL_COUNT   = FL_COUNT_DEF;
    localparam int FL_SHIFT   = FL_SHIFT_DEF;
    localparam int HEAD_DEPTH = FL_COUNT * SL_COUNT;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
    localparam int RANDOM_N   = 530;
    localparam int POOL_N     = 12;

    class tlsf_bitmap_model;
        logic [FL_COUNT-1:0] fl_bits;
        logic [31:0]         sl_bits [FL_COUNT];
        logic [ADDR_W-1:0]   heads [HEAD_DEPTH];
        t_out_item           index_results_due [$];
        int                  failures;
        int                  checked;
        int                  n_range;
        int                  n_empty;

        function new();
            fl_bits = '0;
            foreach (sl_bits[i]) sl_bits[i] = '0;
            foreach (heads[i]) heads[i] = '0;
            failures = 0;
            checked  = 0;
            n_range  = 0;
            n_empty  = 0;
        endfunction

        function int msb(logic [63:0] x);
            int r;
            r = -1;
            for (int i = 0; i < 64; i++) if (x[i]) r = i;
            return r;
        endfunction

        function int lsb(logic [63:0] x);
            for (int i = 0; i < 64; i++) if (x[i]) return i;
            return -1;
        endfunction

        function t_out_item apply_request(t_in_item req);
            t_out_item   res;
            logic [63:0] sz;
            logic [63:0] slm;
            logic [63:0] flm;
            int          fl;
            int          sl;
            int          idx;
            bit          in_range;
            bit          found;
            res        = '0;
            res.status = ST_RANGE;
            fl         = 0;
            sl         = 0;
            in_range   = 0;
            sz         = 64'(req.block_size);
            if (req.operation != OP_UNKNOWN && sz != 0) begin
                // search rounds the request up to the next class boundary
                if (req.operation == OP_SEARCH && sz >= (64'd1 << FL_SHIFT)) begin
                    sz = sz + (64'd1 << (msb(sz) - SLL)) - 64'd1;
                end
                if (sz < (64'd1 << FL_SHIFT)) begin
                    fl = 0;
                    sl = int'((sz >> (FL_SHIFT - SLL)) & 64'(SL_COUNT - 1));
                end else begin
                    sl = int'(((sz >> (msb(sz) - SLL)) ^ 64'(SL_COUNT)) & 64'(SL_COUNT - 1));
                    fl = msb(sz) - (FL_SHIFT - 1);
                end
                in_range = fl < FL_COUNT;
            end
            if (!in_range) begin
                fl = 0;
                sl = 0;
                n_range++;
            end else begin
                idx        = fl * SL_COUNT + sl;
                res.status = ST_OK;
                if (req.operation == OP_INSERT) begin
                    res.head_address = heads[idx];
                    heads[idx]       = req.block_addr;
                    fl_bits[fl]      = 1'b1;
                    sl_bits[fl][sl]  = 1'b1;
                end else if (req.operation == OP_REMOVE) begin
                    if (heads[idx] == req.block_addr) begin
                        heads[idx] = req.next_addr;
                        if (req.next_addr == '0) begin
                            sl_bits[fl][sl] = 1'b0;
                            if (sl_bits[fl] == '0) fl_bits[fl] = 1'b0;
                        end
                    end
                    res.head_address = heads[idx];
                end else begin
                    slm   = 64'(sl_bits[fl]) & (~64'd0 << sl);
                    found = 1'b1;
                    if (slm == '0) begin
                        flm = 64'(fl_bits) & (~64'd0 << (fl + 1));
                        if (flm == '0) begin
                            found = 1'b0;
                        end else begin
                            fl  = lsb(flm);
                            slm = 64'(sl_bits[fl]);
                        end
                    end
                    if (found && slm != '0) begin
                        sl               = lsb(slm);
                        res.head_address = heads[fl * SL_COUNT + sl];
                    end else begin
                        res.status       = ST_EMPTY;
                        res.head_address = '0;
                        n_empty++;
                    end
                end
            end
            res.first_index  = IDX_W'(fl);
            res.second_index = IDX_W'(sl);
            index_results_due.push_back(res);
            return res;
        endfunction

        function void compare_result(t_out_item got);
            t_out_item want;
            if (index_results_due.size() == 0) begin
                $error("result with nothing outstanding: %h", got);
                failures++;
                return;
            end
            want = index_results_due.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.first_index !== want.first_index) begin
                $error("first_index: expected %0d, actual %0d",
                       want.first_index, got.first_index);
                failures++;
            end
            if (got.second_index !== want.second_index) begin
                $error("second_index: expected %0d, actual %0d",
                       want.second_index, got.second_index);
                failures++;
            end
            if (got.head_address !== want.head_address) begin
                $error("head_address: expected %h, actual %h",
                       want.head_address, got.head_address);
                failures++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    tlsf_bitmap_model idx_model = new();

    logic [ADDR_W-1:0] free_chain [HEAD_DEPTH][$];
    int  pool [POOL_N];
    bit  no_gaps = 1'b0;
    int  hold    = 0;
    int  n_insert = 0;
    int  n_remove = 0;
    int  n_search = 0;
    int  n_other  = 0;

    tlsf_free_list_index dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 90) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (no_gaps || $urandom_range(0, 1) == 0) return 0;
        return pick_gap();
    endfunction

    function automatic logic [SIZE_W-1:0] size_in_class(int fl, int sl);
        logic [SIZE_W-1:0] s;
        int                m;
        if (fl == 0) begin
            s = SIZE_W'(sl * 4 + $urandom_range(0, 3));
            if (s == '0) s = SIZE_W'($urandom_range(1, 3));
        end else begin
            m = fl + FL_SHIFT - 1;
            s = (SIZE_W'(1) << m) | (SIZE_W'(sl) << (m - SLL))
                | (SIZE_W'($urandom) & ((SIZE_W'(1) << (m - SLL)) - 1));
        end
        return s;
    endfunction

    function automatic logic [ADDR_W-1:0] nonzero_addr();
        logic [ADDR_W-1:0] a;
        a = $urandom;
        if (a == '0) a = 1;
        return a;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       r;
        int       c;
        int       n;
        int       depth;
        it = '0;
        r  = $urandom_range(0, 99);
        c  = pool[$urandom_range(0, POOL_N - 1)];
        if (r >= 35 && r < 65) begin
            n = -1;
            for (int t = 0; t < 8 && n < 0; t++) begin
                c = pool[$urandom_range(0, POOL_N - 1)];
                if (free_chain[c].size() > 0) n = c;
            end
            if (n >= 0) begin
                depth           = free_chain[n].size();
                it.operation    = OP_REMOVE;
                it.block_size   = size_in_class(n / SL_COUNT, n % SL_COUNT);
                it.block_addr   = free_chain[n][depth - 1];
                it.next_addr    = depth > 1 ? free_chain[n][depth - 2] : '0;
                return it;
            end
            r = 0;
        end
        if (r < 35) begin
            it.operation  = OP_INSERT;
            it.block_size = size_in_class(c / SL_COUNT, c % SL_COUNT);
            it.block_addr = nonzero_addr();
            it.next_addr  = $urandom;
        end else if (r < 85) begin
            it.operation  = OP_SEARCH;
            it.block_size = $urandom_range(0, 1) ? size_in_class(c / SL_COUNT, c % SL_COUNT)
                                                 : ($urandom >> $urandom_range(0, 31));
            it.block_addr = $urandom;
            it.next_addr  = $urandom;
        end else begin
            it.block_addr = $urandom;
            it.next_addr  = $urandom;
            case ($urandom_range(0, 4))
                0: begin
                    it.operation  = OP_W'($urandom_range(0, 3));
                    it.block_size = $urandom;
                end
                1: begin
                    it.operation  = OP_W'($urandom_range(0, 3));
                    it.block_size = '0;
                end
                2: begin
                    it.operation  = OP_W'($urandom_range(0, 2));
                    it.block_size = 32'h4000_0000 | $urandom;
                end
                3: begin
                    it.operation  = OP_REMOVE;
                    it.block_size = size_in_class(c / SL_COUNT, c % SL_COUNT);
                end
                default: begin
                    // head removal with a broken link, or a null block pushed
                    it.block_size = size_in_class(c / SL_COUNT, c % SL_COUNT);
                    if (free_chain[c].size() > 0 && $urandom_range(0, 1)) begin
                        it.operation  = OP_REMOVE;
                        it.block_addr = free_chain[c][free_chain[c].size() - 1];
                    end else begin
                        it.operation  = OP_INSERT;
                        it.block_addr = '0;
                    end
                end
            endcase
        end
        return it;
    endfunction

    // keeps the stimulus view of each class list in step with what was sent
    function automatic void track_chain(t_in_item it, t_out_item res);
        int idx;
        bit hit;
        if (res.status != ST_OK || it.operation == OP_SEARCH) return;
        idx = int'(res.first_index) * SL_COUNT + int'(res.second_index);
        if (it.operation == OP_INSERT) begin
            free_chain[idx].push_back(it.block_addr);
            return;
        end
        hit = free_chain[idx].size() > 0 ? free_chain[idx][free_chain[idx].size() - 1]
                                           == it.block_addr
                                         : it.block_addr == '0;
        if (!hit) return;
        if (free_chain[idx].size() > 0) void'(free_chain[idx].pop_back());
        if (it.next_addr == '0) begin
            free_chain[idx].delete();
        end else if (free_chain[idx].size() == 0
                     || free_chain[idx][free_chain[idx].size() - 1] != it.next_addr) begin
            free_chain[idx].delete();
            free_chain[idx].push_back(it.next_addr);
        end
    endfunction

    task automatic send_item(input t_in_item it);
        int        gap;
        t_out_item res;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        res = idx_model.apply_request(it);
        track_chain(it, res);
        if (it.operation == OP_INSERT) n_insert++;
        else if (it.operation == OP_REMOVE) n_remove++;
        else if (it.operation == OP_SEARCH) n_search++;
        else n_other++;
    endtask

    task automatic put(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
                       input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] nxt);
        t_in_item it;
        it.operation  = op;
        it.block_size = size;
        it.block_addr = addr;
        it.next_addr  = nxt;
        send_item(it);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (idx_model.index_results_due.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) idx_model.compare_result(out_data);
    end

    initial begin
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
            end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                hold = pick_gap() - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        pool[0] = 0;
        pool[1] = HEAD_DEPTH - 1;
        pool[2] = SL_COUNT - 1;
        pool[3] = SL_COUNT;
        for (int i = 4; i < POOL_N; i++) pool[i] = $urandom_range(0, HEAD_DEPTH - 1);
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        put(OP_SEARCH, 32'd1, 32'd0, 32'd0);
        put(OP_INSERT, 32'd0, 32'h0000_1111, 32'd0);
        put(OP_UNKNOWN, 32'd100, 32'h0000_2222, 32'd0);
        put(OP_INSERT, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put(OP_INSERT, 32'd127, 32'h0000_1000, 32'd0);
        put(OP_INSERT, 32'd128, 32'h0000_2000, 32'd0);
        put(OP_INSERT, 32'h3FFF_FFFF, 32'h0000_3000, 32'd0);
        put(OP_INSERT, 32'h4000_0000, 32'h0000_4000, 32'd0);
        put(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_5000, 32'd0);
        put(OP_INSERT, 32'd200, 32'd0, 32'd0);
        put(OP_SEARCH, 32'd0, 32'd0, 32'd0);
        put(OP_SEARCH, 32'h3FFF_FFFF, 32'd0, 32'd0);
        put(OP_SEARCH, 32'h3F00_0000, 32'd0, 32'd0);
        put(OP_SEARCH, 32'd129, 32'd0, 32'd0);
        put(OP_REMOVE, 32'd1, 32'h0000_1234, 32'd0);
        put(OP_REMOVE, 32'd1, 32'hFFFF_FFFF, 32'd0);
        put(OP_REMOVE, 32'd127, 32'h0000_1000, 32'd0);
        put(OP_SEARCH, 32'd1, 32'd0, 32'd0);
        put(OP_REMOVE, 32'd200, 32'd0, 32'hABCD_0000);
        put(OP_REMOVE, 32'h3FFF_FFFF, 32'h0000_3000, 32'd0);
        put(OP_SEARCH, 32'h0200_0000, 32'd0, 32'd0);
        put(OP_REMOVE, 32'd0, 32'd0, 32'd0);
        put(OP_REMOVE, 32'h8000_0000, 32'd0, 32'd0);
        put(OP_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        for (int k = 0; k < RANDOM_N; k++) begin
            no_gaps = ((k / 60) % 4) == 1;
            if (k == RANDOM_N / 2) drain();
            send_item(random_item());
        end
        no_gaps = 1'b0;
        drain();
        repeat (12) @(posedge clk);

        $display("Ran %0d transfers: %0d insert, %0d remove, %0d search, %0d unknown op",
                 n_insert + n_remove + n_search + n_other,
                 n_insert, n_remove, n_search, n_other);
        $display("Compared %0d results; %0d rejected on size or class, %0d searches empty",
                 idx_model.checked, idx_model.n_range, idx_model.n_empty);
        if (idx_model.failures == 0 && idx_model.index_results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/tfli_pkg.sv
rtl/tfli_class_map.sv
rtl/tfli_bitmap.sv
rtl/tfli_head_mem.sv
rtl/tlsf_free_list_index.sv
rtl/tfli_checker.sv
bench/tb_tlsf_free_list_index.sv
